[design/ffbp_pkg.sv]
// ffbp_pkg: shared widths, defaults and control/status types of the
// first-fit bin packer. Depends on nothing; used by every design file.
package ffbp_pkg;

  // Parameter defaults
  localparam int MAX_BINS_DEF  = 256;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed port field widths
  localparam int ITEM_W     = 16;
  localparam int CAP_W      = 16;
  localparam int BIN_NUM_W  = 8;
  localparam int BINS_USE_W = 9;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the incoming item
    logic scan;    // walk the open bins
    logic commit;  // update storage and load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;  // fitting bin found or every open bin examined
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

[design/ffbp_ctrl.sv]
// ffbp_ctrl: sequencing state machine of the first-fit bin packer.
// Depends on ffbp_pkg for the command and status types.
module ffbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffbp_pkg::stat_t  stat,
  output ffbp_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Input is taken only between items
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One command at a time; commit returns to idle, load leads to scan
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("ffbp_ctrl: overlapping commands");
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == ST_IDLE)
    else $error("ffbp_ctrl: commit did not return to idle");
  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan)
    else $error("ffbp_ctrl: load not followed by scan");

endmodule

[design/ffbp_dpath.sv]
// ffbp_dpath: remaining-space memory, scan pipeline, bin count and result
// register of the first-fit bin packer. Depends on ffbp_pkg.
module ffbp_dpath #(
  parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
  parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ffbp_pkg::cmd_t                    cmd,
  output ffbp_pkg::stat_t                   stat,
  input  logic                              cfg_write,
  input  logic [ffbp_pkg::CAP_W-1:0]        cfg_data,
  input  logic [ffbp_pkg::ITEM_W-1:0]       item_size,
  input  logic                              first_of_set,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffbp_pkg::BIN_NUM_W-1:0]    bin_number,
  output logic                              opened_bin,
  output logic [ffbp_pkg::BINS_USE_W-1:0]   bins_in_use,
  output logic                              bins_exhausted
);

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int REM_W = SIZE_BITS + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

  // Remaining space per bin, no reset: entries are written when a bin opens
  logic signed [REM_W-1:0] mem [MAX_BINS];

  logic [SIZE_BITS-1:0]    cap;
  logic [SIZE_BITS-1:0]    size;
  logic [CNT_W-1:0]        open_bins;
  logic [CNT_W-1:0]        addr;
  logic                    rd_vld;
  logic [BIN_W-1:0]        rd_idx;
  logic signed [REM_W-1:0] rd_data;
  logic                    found;
  logic [BIN_W-1:0]        found_idx;
  logic signed [REM_W-1:0] found_rem;

  logic                    issue;
  logic                    hit;
  logic                    can_open;
  logic                    wr_en;
  logic [BIN_W-1:0]        wr_idx;
  logic signed [REM_W-1:0] wr_data;
  logic [BIN_W-1:0]        sel_idx;
  logic [CNT_W-1:0]        cnt_after;
  logic [31:0]             size_wide;
  logic [31:0]             cap_wide;
  logic [31:0]             bin_wide;
  logic [31:0]             cnt_wide;

  // Fields narrowed or widened to the size width
  assign size_wide = 32'(item_size);
  assign cap_wide  = 32'(cfg_data);

  // Scan: one read issued per cycle, compared in the cycle after it is issued
  assign hit      = rd_vld && (rd_data >= $signed({1'b0, size}));
  assign issue    = cmd.scan && !hit && (addr < open_bins);
  assign stat.scan_end = hit || (!rd_vld && (addr >= open_bins));
  assign stat.out_free = !out_valid || !out_stall;

  // Commit: update the fitting bin or open the next one if any is left
  assign can_open  = (open_bins < MAX_CNT);
  assign wr_en     = cmd.commit && (found || can_open);
  assign wr_idx    = found ? found_idx : open_bins[BIN_W-1:0];
  assign wr_data   = found ? (found_rem - $signed({1'b0, size}))
                           : ($signed({1'b0, cap}) - $signed({1'b0, size}));
  assign sel_idx   = (found || !can_open) ? (found ? found_idx : '0)
                                          : open_bins[BIN_W-1:0];
  assign cnt_after = (!found && can_open) ? (open_bins + CNT_W'(1)) : open_bins;
  assign bin_wide  = 32'(sel_idx);
  assign cnt_wide  = 32'(cnt_after);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= SIZE_BITS'(32'(ffbp_pkg::CAP_RESET));
    end else if (cfg_write) begin
      cap <= cap_wide[SIZE_BITS-1:0];
    end
  end

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[addr[BIN_W-1:0]];
    rd_idx  <= addr[BIN_W-1:0];
  end

  // Control state: bin count, scan address, read valid
  always_ff @(posedge clk) begin
    if (rst) begin
      open_bins <= '0;
      addr      <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.load) begin
        addr <= '0;
        if (first_of_set) begin
          open_bins <= '0;
        end
      end else if (issue) begin
        addr <= addr + CNT_W'(1);
      end
      if (cmd.commit) begin
        open_bins <= cnt_after;
      end
    end
  end

  // Item and scan result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size  <= size_wide[SIZE_BITS-1:0];
      found <= 1'b0;
    end else if (cmd.scan && hit) begin
      found     <= 1'b1;
      found_idx <= rd_idx;
      found_rem <= rd_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bin_number     <= bin_wide[ffbp_pkg::BIN_NUM_W-1:0];
      opened_bin     <= !found && can_open;
      bins_in_use    <= cnt_wide[ffbp_pkg::BINS_USE_W-1:0];
      bins_exhausted <= !found && !can_open;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    open_bins <= MAX_CNT)
    else $error("ffbp_dpath: bin count beyond capacity");
  a_rd_open: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CNT_W'(rd_idx) < open_bins))
    else $error("ffbp_dpath: read of a bin that is not open");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rd_vld)
    else $error("ffbp_dpath: commit with a read in flight");
  a_hit_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit) |=> !rd_vld)
    else $error("ffbp_dpath: scan continued past a fitting bin");

endmodule

[design/first_fit_bin_packer_unit.sv]
// The item is latched, the open bins are read and compared in order until one fits
// or all are examined, then the commit updates storage and loads the result register.
// Input is taken only in the idle state, so an item waits for the last one's commit,
// which a stalled result holds. A waiting result does not block the next transfer in.
// Reset (rst, synchronous): no bins open, capacity 65535, no result pending.
// first_fit_bin_packer_unit: top level; depends on ffbp_pkg, ffbp_ctrl, ffbp_dpath.
module first_fit_bin_packer_unit #(
  parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
  parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ffbp_pkg::CAP_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ffbp_pkg::ITEM_W-1:0]       item_size,
  input  logic                              first_of_set,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffbp_pkg::BIN_NUM_W-1:0]    bin_number,
  output logic                              opened_bin,
  output logic [ffbp_pkg::BINS_USE_W-1:0]   bins_in_use,
  output logic                              bins_exhausted
);

  ffbp_pkg::cmd_t  cmd;
  ffbp_pkg::stat_t stat;

  // Sequencer
  ffbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  ffbp_dpath #(
    .MAX_BINS  (MAX_BINS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .item_size      (item_size),
    .first_of_set   (first_of_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bin_number     (bin_number),
    .opened_bin     (opened_bin),
    .bins_in_use    (bins_in_use),
    .bins_exhausted (bins_exhausted)
  );

endmodule

[test/first_fit_bin_packer_unit_tb.sv]
// first_fit_bin_packer_unit_tb: self-checking testbench for the first-fit bin packer.
// Depends on ffbp_pkg and first_fit_bin_packer_unit; a scoreboard class predicts
// every result while plain tasks drive the item and capacity ports and an always block the result stall.

// One packing result as the block reports it
typedef struct {
  logic [ffbp_pkg::BIN_NUM_W-1:0]  bin;
  logic                            opened;
  logic [ffbp_pkg::BINS_USE_W-1:0] in_use;
  logic                            exhausted;
} bin_result_t;

// Tracks the bins as the block should see them and queues the expected placements
class packing_scoreboard;
  logic signed [ffbp_pkg::SIZE_BITS_DEF:0] space [ffbp_pkg::MAX_BINS_DEF];
  int                                      open_count;
  logic [ffbp_pkg::CAP_W-1:0]              capacity;
  bin_result_t                             placements_q[$];
  int                                      errors;

  function new();
    open_count = 0;
    capacity   = ffbp_pkg::CAP_RESET;
    errors     = 0;
  endfunction

  function void set_capacity(input logic [ffbp_pkg::CAP_W-1:0] cap);
    capacity = cap;
  endfunction

  function int pending();
    return placements_q.size();
  endfunction

  // Place one accepted item first-fit and queue the placement it should produce
  function void note_item(input logic [ffbp_pkg::ITEM_W-1:0] size, input logic first);
    logic signed [ffbp_pkg::SIZE_BITS_DEF:0] need;
    bin_result_t                             res;
    bit                                      placed;
    int                                      j;
    need          = $signed({1'b0, size});
    res.bin       = '0;
    res.opened    = 1'b0;
    res.exhausted = 1'b0;
    placed        = 1'b0;
    if (first) begin
      open_count = 0;
    end
    // lowest-numbered bin with room wins
    for (j = 0; j < open_count && !placed; j++) begin
      if (space[j] >= need) begin
        space[j] = space[j] - need;
        res.bin  = j[ffbp_pkg::BIN_NUM_W-1:0];
        placed   = 1'b1;
      end
    end
    if (!placed) begin
      if (open_count < ffbp_pkg::MAX_BINS_DEF) begin
        // oversize items leave a negative space behind
        space[open_count] = $signed({1'b0, capacity}) - need;
        res.bin           = open_count[ffbp_pkg::BIN_NUM_W-1:0];
        res.opened        = 1'b1;
        open_count++;
      end else begin
        res.exhausted = 1'b1;
      end
    end
    res.in_use = open_count[ffbp_pkg::BINS_USE_W-1:0];
    placements_q.push_back(res);
  endfunction

  task report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Compare one result transfer with the oldest queued placement
  task check_result(input logic [ffbp_pkg::BIN_NUM_W-1:0] bin, input logic opened,
                    input logic [ffbp_pkg::BINS_USE_W-1:0] in_use, input logic exhausted);
    bin_result_t exp;
    if (placements_q.size() == 0) begin
      report("result transfer with no placement outstanding");
      return;
    end
    exp = placements_q.pop_front();
    if (bin !== exp.bin)
      report($sformatf("bin_number %0d, want %0d", bin, exp.bin));
    if (opened !== exp.opened)
      report($sformatf("opened_bin %0b, want %0b", opened, exp.opened));
    if (in_use !== exp.in_use)
      report($sformatf("bins_in_use %0d, want %0d", in_use, exp.in_use));
    if (exhausted !== exp.exhausted)
      report($sformatf("bins_exhausted %0b, want %0b", exhausted, exp.exhausted));
  endtask
endclass

module first_fit_bin_packer_unit_tb;

  localparam int PRESSURE_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 80;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [ffbp_pkg::CAP_W-1:0]        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ffbp_pkg::ITEM_W-1:0]       item_size = '0;
  logic                              first_of_set = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ffbp_pkg::BIN_NUM_W-1:0]    bin_number;
  logic                              opened_bin;
  logic [ffbp_pkg::BINS_USE_W-1:0]   bins_in_use;
  logic                              bins_exhausted;

  logic hold_off    = 1'b0;
  logic pressure_go = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  packing_scoreboard sb;

  first_fit_bin_packer_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .item_size      (item_size),
    .first_of_set   (first_of_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bin_number     (bin_number),
    .opened_bin     (opened_bin),
    .bins_in_use    (bins_in_use),
    .bins_exhausted (bins_exhausted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(bin_number, opened_bin, bins_in_use, bins_exhausted);
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off so the block backs up onto its input
  initial begin : hold_off_ctrl
    wait (pressure_go);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit
  initial begin : watchdog
    #20000000;
    $display("[first_fit_bin_packer_unit] ERROR");
    $finish;
  end

  // Offer one item, with random idle cycles ahead of it; returns on the transfer
  task automatic send_item(input logic [ffbp_pkg::ITEM_W-1:0] size, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    item_size    <= size;
    first_of_set <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(size, first);
  endtask

  // Let the block run dry, then write a new bin capacity
  task automatic write_capacity(input logic [ffbp_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_capacity(cap);
  endtask

  initial begin : stimulus
    int cap_plan [8];
    int idle_plan[4];
    int stall_plan[4];
    int sizes[$];
    int ph, taken, n, kind, lo, hi, cur_cap;
    bit long_set, noise, fresh;

    cap_plan   = '{65535, 1000, 1, 0, -1, 255, -1, 50};
    idle_plan  = '{0, 78, 0, 36};
    stall_plan = '{0, 0, 78, 36};
    sb = new();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, exact fits, zero size, bit patterns
    send_item(16'hFFFF, 1'b1);
    send_item(16'd0,    1'b0);
    send_item(16'd1,    1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFE, 1'b0);
    send_item(16'd40000, 1'b1);
    send_item(16'd30000, 1'b0);
    send_item(16'd25535, 1'b0);
    send_item(16'd20000, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    // oversize items, zero size skipping negative bins, unsorted arrivals
    write_capacity(16'd100);
    send_item(16'd200, 1'b1);
    send_item(16'd0,   1'b0);
    send_item(16'd150, 1'b0);
    send_item(16'd100, 1'b0);
    send_item(16'd30,  1'b0);
    send_item(16'd60,  1'b0);
    send_item(16'd0,   1'b0);
    // zero capacity: only zero-size items fit anywhere
    write_capacity(16'd0);
    send_item(16'd0,    1'b1);
    send_item(16'd0,    1'b0);
    send_item(16'd5,    1'b0);
    send_item(16'd0,    1'b0);
    send_item(16'hFFFF, 1'b0);

    // Random phases: mostly sorted sets, some ascending sets and raw noise
    for (ph = 0; ph < 8; ph++) begin
      cur_cap = (cap_plan[ph] < 0) ? int'($urandom_range(65534, 2)) : cap_plan[ph];
      write_capacity(cur_cap[ffbp_pkg::CAP_W-1:0]);
      send_idle_pct = idle_plan[ph % 4];
      recv_stall_pct <= stall_plan[ph % 4];
      if (ph == 0) begin
        pressure_go <= 1'b1;
      end
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        // a full set that runs every bin out opens the exhaustion phases
        long_set = (taken == 0) && (ph == 2 || ph == 5);
        kind     = $urandom_range(99);
        noise    = !long_set && kind >= 88;
        fresh    = long_set || ($urandom_range(9) != 0);
        n        = long_set ? $urandom_range(262, 257) : $urandom_range(24, 1);
        hi       = (cur_cap == 0) ? 15 : cur_cap;
        if (long_set) begin
          lo = hi / 2 + 1;
        end else begin
          lo = ($urandom_range(1) != 0) ? 0 : hi / 4;
          if ($urandom_range(9) == 0) begin
            hi = (hi + hi / 4 > 65535) ? 65535 : hi + hi / 4;
          end
        end
        sizes.delete();
        repeat (n) begin
          sizes.push_back(noise ? int'($urandom_range(65535, 0)) : int'($urandom_range(hi, lo)));
        end
        if (long_set || kind < 75) begin
          sizes.rsort();
        end else if (!noise) begin
          sizes.sort();
        end
        foreach (sizes[i]) begin
          send_item(16'(sizes[i]), noise ? ($urandom_range(4) == 0) : (fresh && i == 0));
        end
        taken += n;
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (ffbp_pkg::MAX_BINS_DEF + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[first_fit_bin_packer_unit] OK");
    end else begin
      $display("[first_fit_bin_packer_unit] ERROR");
    end
    $finish;
  end

endmodule
